// File: hdl/s5lab_pkg.sv
// Package for the SHA-512 base32 label pipeline.
// Holds round constants, initial hash words and the SHA-512 helper functions.
// No dependencies.
`timescale 1ns / 1ps
package s5lab_pkg;

   localparam int ROUNDS = 80;

   typedef logic [63:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } state_type;

   localparam word_type INIT_H [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam word_type PAD_WORD = 64'h8000000000000000;
   localparam word_type LEN_WORD = 64'd256;
   localparam int LABEL_CHARS = 32;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic state_type round_fn(input state_type s, input word_type kw);
      word_type t1;
      word_type t2;
      state_type r;
      t1 = s.h + (rotr(s.e, 14) ^ rotr(s.e, 18) ^ rotr(s.e, 41))
           + ((s.e & s.f) ^ (~s.e & s.g)) + kw;
      t2 = (rotr(s.a, 28) ^ rotr(s.a, 34) ^ rotr(s.a, 39))
           + ((s.a & s.b) ^ (s.a & s.c) ^ (s.b & s.c));
      r.h = s.g;
      r.g = s.f;
      r.f = s.e;
      r.e = s.d + t1;
      r.d = s.c;
      r.c = s.b;
      r.b = s.a;
      r.a = t1 + t2;
      round_fn = r;
   endfunction

   function automatic logic [7:0] b32_char(input logic [4:0] v);
      if (v < 5'd26) begin
         b32_char = 8'h61 + {3'b000, v};
      end else begin
         b32_char = 8'h32 + {3'b000, v - 5'd26};
      end
   endfunction

endpackage

// File: hdl/s5lab_round.sv
// One SHA-512 round stage with its message schedule window.
// Uses s5lab_pkg for the round function and schedule sigmas.
`timescale 1ns / 1ps
module s5lab_round
   import s5lab_pkg::*;
#(
   parameter int RoundIdx = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  state_type state_in,
   input  word_type  sched_in [16],
   output logic      valid_out,
   output state_type state_out,
   output word_type  sched_out [16]
);

   logic      valid_ff;
   state_type state_ff;
   word_type  sched_ff [16];
   word_type  new_w;

   // The window holds w[i..i+15]; the next schedule word is appended at the top.
   assign new_w = sched_in[0] + sig0(sched_in[1]) + sched_in[9] + sig1(sched_in[14]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= round_fn(state_in, ROUND_K[RoundIdx] + sched_in[0]);
         for (int j = 0; j < 15; j++) begin
            sched_ff[j] <= sched_in[j + 1];
         end
         sched_ff[15] <= new_w;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign sched_out = sched_ff;

endmodule

// File: hdl/s5lab_encode.sv
// Final digest addition and base32 encoding stage.
// Uses s5lab_pkg for initial hash words and the character map.
`timescale 1ns / 1ps
module s5lab_encode
   import s5lab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        valid_in,
   input  state_type   state_in,
   output logic        valid_out,
   output logic [255:0] label_out
);

   logic         valid_ff;
   logic [255:0] label_ff;
   logic [255:0] label_in;
   logic [191:0] dig;

   always_comb begin
      dig[191:128] = INIT_H[0] + state_in.a;
      dig[127:64]  = INIT_H[1] + state_in.b;
      dig[63:0]    = INIT_H[2] + state_in.c;
      for (int i = 0; i < LABEL_CHARS; i++) begin
         label_in[255 - 8 * i -: 8] = b32_char(dig[191 - 5 * i -: 5]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         label_ff <= label_in;
      end
   end

   assign valid_out = valid_ff;
   assign label_out = label_ff;

endmodule

// File: hdl/sha512_base32_label.sv
// The pipeline has 80 SHA-512 round stages and one encode stage.
// Throughput is one request per cycle while the output is not stalled; the whole pipeline advances together.
// A stalled output freezes every stage, so no request is lost or repeated.
// Reset is synchronous and clears only the valid bits of each stage.
// Depends on s5lab_pkg, s5lab_round and s5lab_encode.
`timescale 1ns / 1ps
module sha512_base32_label
   import s5lab_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // key_word0, key_word1, key_word2, key_word3 from the lowest bit up.
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // label_chars0, label_chars1, label_chars2, label_chars3 from the lowest bit up.
   output logic [255:0] rsp_tdata
);

   logic      advance;
   logic      valid_s [ROUNDS + 1];
   state_type state_s [ROUNDS + 1];
   word_type  sched_s [ROUNDS + 1][16];
   logic [255:0] label;

   assign advance    = rsp_tready || !rsp_tvalid;
   assign req_tready = advance;

   always_comb begin
      valid_s[0] = req_tvalid;
      state_s[0] = '{INIT_H[0], INIT_H[1], INIT_H[2], INIT_H[3],
                     INIT_H[4], INIT_H[5], INIT_H[6], INIT_H[7]};
      sched_s[0][0] = req_tdata[63:0];
      sched_s[0][1] = req_tdata[127:64];
      sched_s[0][2] = req_tdata[191:128];
      sched_s[0][3] = req_tdata[255:192];
      sched_s[0][4] = PAD_WORD;
      for (int j = 5; j < 15; j++) begin
         sched_s[0][j] = '0;
      end
      sched_s[0][15] = LEN_WORD;
   end

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      s5lab_round #(.RoundIdx(r)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_s[r]),
         .state_in  (state_s[r]),
         .sched_in  (sched_s[r]),
         .valid_out (valid_s[r + 1]),
         .state_out (state_s[r + 1]),
         .sched_out (sched_s[r + 1])
      );
   end

   s5lab_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (valid_s[ROUNDS]),
      .state_in  (state_s[ROUNDS]),
      .valid_out (rsp_tvalid),
      .label_out (label)
   );

   assign rsp_tdata = {label[63:0], label[127:64], label[191:128], label[255:192]};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_s[1])
      else $error("accepted request not in first stage");

endmodule

// File: dv/tb.sv
// Testbench for sha512_base32_label: checks SHA-512 of a 32-byte key, cut to
// 160 bits and encoded as 32 base32 characters, against a local model.
// Depends on s5lab_pkg for word types and constants.
`timescale 1ns / 1ps
module tb;
   import s5lab_pkg::*;

   localparam int LATENCY = 81;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;

   logic [255:0] label_queue [$];
   int  errors;
   int  idle_cycles;
   bit  send_gaps;
   bit  recv_gaps;
   int  hold_starts;
   bit  done;

   sha512_base32_label dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [63:0] ror64(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [7:0] base32_ascii(logic [4:0] v);
      if (v < 5'd26) begin
         return 8'h61 + {3'b000, v};
      end
      return 8'h32 + {3'b000, v} - 8'd26;
   endfunction

   function automatic logic [255:0] compute_label(logic [255:0] key);
      logic [63:0]  w [80];
      logic [63:0]  st [8];
      logic [63:0]  t1, t2, s0, s1;
      logic [191:0] digest;
      logic [159:0] bits;
      logic [63:0]  words [4];
      for (int i = 0; i < 4; i++) w[i] = key[64*i +: 64];
      w[4] = PAD_WORD;
      for (int i = 5; i < 15; i++) w[i] = '0;
      w[15] = LEN_WORD;
      for (int i = 16; i < 80; i++) begin
         s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
         s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) st[i] = INIT_H[i];
      for (int i = 0; i < 80; i++) begin
         t1 = st[7] + (ror64(st[4], 14) ^ ror64(st[4], 18) ^ ror64(st[4], 41))
              + ((st[4] & st[5]) ^ (~st[4] & st[6])) + ROUND_K[i] + w[i];
         t2 = (ror64(st[0], 28) ^ ror64(st[0], 34) ^ ror64(st[0], 39))
              + ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
         for (int j = 7; j > 0; j--) st[j] = st[j-1];
         st[4] = st[4] + t1;
         st[0] = t1 + t2;
      end
      digest = {INIT_H[0] + st[0], INIT_H[1] + st[1], INIT_H[2] + st[2]};
      bits = digest[191:32];
      for (int o = 0; o < 32; o++) begin
         words[o / 8][56 - 8 * (o % 8) +: 8] = base32_ascii(bits[155 - 5 * o +: 5]);
      end
      return {words[3], words[2], words[1], words[0]};
   endfunction

   task automatic send_key(logic [255:0] key);
      int gap;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      label_queue.push_back(compute_label(key));
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_key('0);
      send_key('1);
      for (int i = 0; i < 4; i++) begin
         send_key(256'hffff_ffff_ffff_ffff << (64 * i));
         send_key(~(256'hffff_ffff_ffff_ffff << (64 * i)));
      end
      send_key({4{64'h0000_0000_0000_0001}});
      send_key({4{64'h8000_0000_0000_0000}});
      send_key({4{64'haaaa_aaaa_aaaa_aaaa}});
      send_key({4{64'h5555_5555_5555_5555}});
      for (int i = 0; i < 8; i++) send_key(256'd1 << (32 * i + i));
      idle_sender();
   endtask

   task automatic test_random_keys(int count);
      for (int i = 0; i < count; i++) begin
         send_key({$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom});
      end
      idle_sender();
   endtask

   task automatic test_backpressure();
      hold_starts++;
      test_random_keys(150);
   endtask

   always @(posedge clock) begin
      int gap_left;
      int hold_left;
      int hold_taken;
      if (reset) begin
         rsp_tready <= 1'b0;
         gap_left = 0;
         hold_left = 0;
         hold_taken = hold_starts;
      end else if (hold_taken != hold_starts) begin
         hold_taken = hold_starts;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [255:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (label_queue.size() == 0) begin
            $error("unexpected label: actual %h", rsp_tdata);
            errors++;
         end else begin
            want = label_queue.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (rsp_tdata[64*i +: 64] !== want[64*i +: 64]) begin
                  $error("label_chars%0d: expected %h actual %h",
                         i, want[64*i +: 64], rsp_tdata[64*i +: 64]);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || done) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      done        = 1'b0;
      send_gaps   = 1'b1;
      recv_gaps   = 1'b1;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_keys(650);
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      test_random_keys(230);
      while (label_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      done = 1'b1;
      if (errors == 0 && label_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
